/* sv/mptl_pkg.sv */
// ----------------------------------------------------------------------------
// mptl_pkg
// Types and constants of the motor power torque limiter.
// ----------------------------------------------------------------------------
package mptl_pkg;

  localparam int TORQUE_CLAMP    = 16000;
  localparam int COEFF_FRAC_BITS = 40;
  localparam int SH              = COEFF_FRAC_BITS - 16;

  localparam int CFG_ADDR_W  = 5;
  localparam int DIV_STAGES  = 58;
  localparam int SQRT_STAGES = 49;
  localparam int QDIV_STAGES = $clog2(TORQUE_CLAMP + 1);

  localparam logic [31:0] K1_RST   = 32'd135240;
  localparam logic [31:0] K2_RST   = 32'd159757;
  localparam logic [31:0] TC_RST   = 32'd2195588;
  localparam logic [23:0] C0_RST   = 24'd267452;
  localparam logic [25:0] PLIM_RST = 26'd5242880;

  typedef enum logic [2:0] {
    REG_K1   = 3'd0,
    REG_K2   = 3'd1,
    REG_TC   = 3'd2,
    REG_C0   = 3'd3,
    REG_PLIM = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_NORMAL   = 2'd0,
    ST_PASS     = 2'd1,
    ST_NEG_DISC = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [14:0] t;
    logic signed [31:0] p;
    logic               pass;
    logic signed [47:0] b;
    logic        [60:0] kww;
    logic               cpos;
    logic               ndisc;
    logic               keep;
    logic               hi;
    logic               lo;
    logic               nneg;
  } ctx_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [57:0] dq;
    logic [30:0] den;
    logic        neg;
  } div_t;

  typedef struct packed {
    logic [50:0] rem;
    logic [48:0] root;
    logic [97:0] dsh;
  } sq_t;

  typedef struct packed {
    logic [51:0]            rem;
    logic [QDIV_STAGES-1:0] q;
  } qd_t;

  typedef struct packed {
    logic signed [14:0] limited_torque;
    logic signed [31:0] expected_power;
    status_t            status;
  } res_t;

endpackage

/* sv/mptl_in_if.sv */
// ----------------------------------------------------------------------------
// mptl_in_if
// Request channel: rotor speed, torque request and summed power.
// ----------------------------------------------------------------------------
interface mptl_in_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] rotor_speed;
  logic signed [14:0] torque_request;
  logic signed [31:0] total_expected_power;

  modport source (output valid, output rotor_speed, output torque_request,
                  output total_expected_power, input ready);
  modport sink (input valid, input rotor_speed, input torque_request,
                input total_expected_power, output ready);
endinterface

/* sv/mptl_out_if.sv */
// ----------------------------------------------------------------------------
// mptl_out_if
// Result channel: limited torque, expected power and status.
// ----------------------------------------------------------------------------
interface mptl_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] limited_torque;
  logic signed [31:0] expected_power;
  logic        [1:0]  status;

  modport source (output valid, output limited_torque, output expected_power,
                  output status, input ready);
  modport sink (input valid, input limited_torque, input expected_power,
                input status, output ready);
endinterface

/* sv/motor_power_torque_limiter.sv */
// ----------------------------------------------------------------------------
// motor_power_torque_limiter
// Power estimate and power-limited torque command for one motor.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request item (rotor speed, torque request, summed
//   power of all motors); out_ch returns one result item per request, in
//   order. Both use valid/ready; an item moves when both are high.
//   Coefficients are written over the APB-style cfg_ port while no item is
//   in flight; cfg_pready is always high and reads return the register.
//   From accept to out_ch.valid an item passes 6 front stages, a
//   58-stage radix-2 divider for the power scale, 6 stages forming the
//   discriminant, a 49-stage square root, 3 decision stages, a 14-stage
//   divider for the root and the output register.
//   Throughput is one item per cycle unless out_ch stalls; every stage holds one item.
//   When out_ch stalls, one more item lands in a skid register, then the
//   whole pipeline holds and in_ch.ready drops until out_ch is drained.
//   Reset (synchronous, rst_n low) empties the pipeline and loads the
//   register defaults.
// ----------------------------------------------------------------------------
module motor_power_torque_limiter
  import mptl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mptl_in_if.sink               in_ch,
  mptl_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam logic signed [59:0] E_HI  = 60'sd1 <<< (62 - SH);
  localparam logic signed [59:0] E_LO  = -(60'sd1 <<< (63 - SH));
  localparam logic signed [65:0] LIM   = 66'sd1 <<< 62;
  localparam logic signed [14:0] CLAMP = 15'(TORQUE_CLAMP);

  logic [31:0] k1_r, k2_r, tc_r;
  logic [23:0] c0_r;
  logic [25:0] plim_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  logic en;
  logic out_valid_r, skid_v_r;
  res_t out_r, skid_r, pd;
  logic pv;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r   <= K1_RST;
      k2_r   <= K2_RST;
      tc_r   <= TC_RST;
      c0_r   <= C0_RST;
      plim_r <= PLIM_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_K1:   k1_r   <= cfg_pwdata;
        REG_K2:   k2_r   <= cfg_pwdata;
        REG_TC:   tc_r   <= cfg_pwdata;
        REG_C0:   c0_r   <= cfg_pwdata[23:0];
        REG_PLIM: plim_r <= cfg_pwdata[25:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_K1:   cfg_prdata = k1_r;
      REG_K2:   cfg_prdata = k2_r;
      REG_TC:   cfg_prdata = tc_r;
      REG_C0:   cfg_prdata = {8'd0, c0_r};
      REG_PLIM: cfg_prdata = {6'd0, plim_r};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // stage 1: small products
  logic               s1_v_r;
  logic signed [14:0] s1_w_r, s1_t_r;
  logic signed [31:0] s1_tot_r;
  logic signed [29:0] s1_tw_r, tw_nxt, ww_nxt, tt_nxt;
  logic        [28:0] s1_ww_r, s1_tt_r;

  assign tw_nxt = in_ch.rotor_speed * in_ch.torque_request;
  assign ww_nxt = in_ch.rotor_speed * in_ch.rotor_speed;
  assign tt_nxt = in_ch.torque_request * in_ch.torque_request;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_w_r   <= in_ch.rotor_speed;
      s1_t_r   <= in_ch.torque_request;
      s1_tot_r <= in_ch.total_expected_power;
      s1_tw_r  <= tw_nxt;
      s1_ww_r  <= ww_nxt[28:0];
      s1_tt_r  <= tt_nxt[28:0];
    end
  end

  // stage 2: coefficient products
  logic               s2_v_r;
  logic signed [14:0] s2_t_r;
  logic signed [31:0] s2_tot_r;
  logic signed [62:0] s2_m1_r, m1_nxt;
  logic        [60:0] s2_m2_r, s2_m3_r, m2_nxt, m3_nxt;
  logic signed [47:0] s2_b_r, b_nxt;

  assign m1_nxt = $signed({1'b0, tc_r}) * s1_tw_r;
  assign m2_nxt = k2_r * s1_ww_r;
  assign m3_nxt = k1_r * s1_tt_r;
  assign b_nxt  = $signed({1'b0, tc_r}) * s1_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_t_r   <= s1_t_r;
      s2_tot_r <= s1_tot_r;
      s2_m1_r  <= m1_nxt;
      s2_m2_r  <= m2_nxt;
      s2_m3_r  <= m3_nxt;
      s2_b_r   <= b_nxt;
    end
  end

  // stage 3: power sum
  logic               s3_v_r;
  logic signed [14:0] s3_t_r;
  logic signed [31:0] s3_tot_r;
  logic signed [63:0] s3_n_r, n_nxt;
  logic        [60:0] s3_kww_r;
  logic signed [47:0] s3_b_r;

  assign n_nxt = 64'(s2_m1_r) + 64'(s2_m2_r) + 64'(s2_m3_r) + (64'(c0_r) << SH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_t_r   <= s2_t_r;
      s3_tot_r <= s2_tot_r;
      s3_n_r   <= n_nxt;
      s3_kww_r <= s2_m2_r;
      s3_b_r   <= s2_b_r;
    end
  end

  // stage 4: scale and saturate
  logic               s4_v_r;
  logic signed [14:0] s4_t_r;
  logic signed [31:0] s4_tot_r;
  logic signed [31:0] s4_p_r, p_nxt;
  logic signed [63:0] nsh_nxt;
  logic        [60:0] s4_kww_r;
  logic signed [47:0] s4_b_r;

  assign nsh_nxt = s3_n_r >>> SH;

  always_comb begin
    if (nsh_nxt > 64'sh7FFF_FFFF) begin
      p_nxt = 32'sh7FFF_FFFF;
    end else if (nsh_nxt < -64'sh8000_0000) begin
      p_nxt = 32'sh8000_0000;
    end else begin
      p_nxt = nsh_nxt[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_t_r   <= s3_t_r;
      s4_tot_r <= s3_tot_r;
      s4_p_r   <= p_nxt;
      s4_kww_r <= s3_kww_r;
      s4_b_r   <= s3_b_r;
    end
  end

  // stage 5: power times limit
  logic               s5_v_r;
  logic signed [14:0] s5_t_r;
  logic signed [31:0] s5_tot_r;
  logic signed [31:0] s5_p_r;
  logic signed [58:0] s5_prod_r, prod_nxt;
  logic        [60:0] s5_kww_r;
  logic signed [47:0] s5_b_r;

  assign prod_nxt = s4_p_r * $signed({1'b0, plim_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_t_r    <= s4_t_r;
      s5_tot_r  <= s4_tot_r;
      s5_p_r    <= s4_p_r;
      s5_prod_r <= prod_nxt;
      s5_kww_r  <= s4_kww_r;
      s5_b_r    <= s4_b_r;
    end
  end

  // stage 6: divider operands
  logic        s6_v_r;
  ctx_t        s6_ctx_r, s6_ctx_nxt;
  div_t        s6_div_r, s6_div_nxt;
  logic [58:0] prod_neg_nxt;

  assign prod_neg_nxt = 59'(-s5_prod_r);

  always_comb begin
    s6_ctx_nxt      = '0;
    s6_ctx_nxt.t    = s5_t_r;
    s6_ctx_nxt.p    = s5_p_r;
    s6_ctx_nxt.pass = (s5_tot_r <= 32'sd0);
    s6_ctx_nxt.b    = s5_b_r;
    s6_ctx_nxt.kww  = s5_kww_r;
    s6_div_nxt.rem  = '0;
    s6_div_nxt.dq   = s5_prod_r[58] ? prod_neg_nxt[57:0] : s5_prod_r[57:0];
    s6_div_nxt.den  = s5_tot_r[30:0];
    s6_div_nxt.neg  = s5_prod_r[58];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ctx_r <= s6_ctx_nxt;
      s6_div_r <= s6_div_nxt;
    end
  end

  // power scale divider, one quotient bit per stage
  div_t                  div_r  [DIV_STAGES];
  ctx_t                  divc_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] div_v_r;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    div_t        dv_in, dv_nxt;
    ctx_t        cx_in;
    logic        v_in;
    logic [31:0] tmp;

    if (k == 0) begin : g_first
      assign dv_in = s6_div_r;
      assign cx_in = s6_ctx_r;
      assign v_in  = s6_v_r;
    end else begin : g_next
      assign dv_in = div_r[k-1];
      assign cx_in = divc_r[k-1];
      assign v_in  = div_v_r[k-1];
    end

    always_comb begin
      tmp    = {dv_in.rem, dv_in.dq[57]};
      dv_nxt = dv_in;
      if (tmp >= {1'b0, dv_in.den}) begin
        dv_nxt.rem = 31'(tmp - {1'b0, dv_in.den});
        dv_nxt.dq  = {dv_in.dq[56:0], 1'b1};
      end else begin
        dv_nxt.rem = tmp[30:0];
        dv_nxt.dq  = {dv_in.dq[56:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_v_r[k] <= 1'b0;
      end else if (en) begin
        div_v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k]  <= dv_nxt;
        divc_r[k] <= cx_in;
      end
    end
  end

  // stage E: loss margin
  logic               e_v_r;
  ctx_t               e_ctx_r;
  logic signed [59:0] e_r, e_nxt;
  logic signed [58:0] ps_nxt, q_pos;

  assign q_pos  = $signed({1'b0, div_r[DIV_STAGES-1].dq});
  assign ps_nxt = div_r[DIV_STAGES-1].neg ? -q_pos : q_pos;
  assign e_nxt  = $signed(60'(c0_r)) - 60'(ps_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= div_v_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r     <= e_nxt;
      e_ctx_r <= divc_r[DIV_STAGES-1];
    end
  end

  // stage C1: constant term sum and |b|
  logic               c1_v_r, c1_hi_r, c1_lo_r;
  ctx_t               c1_ctx_r;
  logic signed [65:0] c1_sum_r, sum_nxt;
  logic        [46:0] c1_babs_r;
  logic        [47:0] bneg_nxt;

  assign sum_nxt  = (66'(e_r) <<< SH) + $signed(66'(e_ctx_r.kww));
  assign bneg_nxt = 48'(-e_ctx_r.b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_ctx_r  <= e_ctx_r;
      c1_hi_r   <= (e_r > E_HI);
      c1_lo_r   <= (e_r < E_LO);
      c1_sum_r  <= sum_nxt;
      c1_babs_r <= e_ctx_r.b[47] ? bneg_nxt[46:0] : e_ctx_r.b[46:0];
    end
  end

  // stage C2: clamp constant term
  logic               c2_v_r;
  ctx_t               c2_ctx_r, c2_ctx_nxt;
  logic        [62:0] c2_cabs_r;
  logic        [46:0] c2_babs_r;
  logic signed [65:0] c_nxt, cneg_nxt;

  always_comb begin
    if (c1_hi_r) begin
      c_nxt = LIM;
    end else if (c1_lo_r) begin
      c_nxt = -LIM;
    end else if (c1_sum_r > LIM) begin
      c_nxt = LIM;
    end else if (c1_sum_r < -LIM) begin
      c_nxt = -LIM;
    end else begin
      c_nxt = c1_sum_r;
    end
    cneg_nxt        = -c_nxt;
    c2_ctx_nxt      = c1_ctx_r;
    c2_ctx_nxt.cpos = (c_nxt > 66'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_v_r <= 1'b0;
    end else if (en) begin
      c2_v_r <= c1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_ctx_r  <= c2_ctx_nxt;
      c2_cabs_r <= c_nxt[65] ? cneg_nxt[62:0] : c_nxt[62:0];
      c2_babs_r <= c1_babs_r;
    end
  end

  // stage M1: partial products
  logic        m1_v_r;
  ctx_t        m1_ctx_r;
  logic [47:0] m1_bll_r;
  logic [46:0] m1_blh_r;
  logic [45:0] m1_bhh_r;
  logic [63:0] m1_acl_r;
  logic [62:0] m1_ach_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= c2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_ctx_r <= c2_ctx_r;
      m1_bll_r <= c2_babs_r[23:0] * c2_babs_r[23:0];
      m1_blh_r <= c2_babs_r[23:0] * c2_babs_r[46:24];
      m1_bhh_r <= c2_babs_r[46:24] * c2_babs_r[46:24];
      m1_acl_r <= k1_r * c2_cabs_r[31:0];
      m1_ach_r <= k1_r * c2_cabs_r[62:32];
    end
  end

  // stage M2: b^2 and 4ac
  logic        m2_v_r;
  ctx_t        m2_ctx_r;
  logic [97:0] m2_bsq_r, m2_ac4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (en) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_ctx_r <= m1_ctx_r;
      m2_bsq_r <= (98'(m1_bhh_r) << 48) + (98'(m1_blh_r) << 25) + 98'(m1_bll_r);
      m2_ac4_r <= ((98'(m1_ach_r) << 32) + 98'(m1_acl_r)) << 2;
    end
  end

  // stage M3: discriminant
  logic        m3_v_r;
  ctx_t        m3_ctx_r, m3_ctx_nxt;
  sq_t         m3_sq_r, m3_sq_nxt;
  logic [98:0] diff_nxt;

  assign diff_nxt = {1'b0, m2_bsq_r} - {1'b0, m2_ac4_r};

  always_comb begin
    m3_ctx_nxt       = m2_ctx_r;
    m3_sq_nxt.rem    = '0;
    m3_sq_nxt.root   = '0;
    if (!m2_ctx_r.cpos) begin
      m3_sq_nxt.dsh = m2_bsq_r + m2_ac4_r;
    end else if (diff_nxt[98]) begin
      m3_sq_nxt.dsh    = '0;
      m3_ctx_nxt.ndisc = 1'b1;
    end else begin
      m3_sq_nxt.dsh = diff_nxt[97:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else if (en) begin
      m3_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_ctx_r <= m3_ctx_nxt;
      m3_sq_r  <= m3_sq_nxt;
    end
  end

  // square root, one root bit per stage
  sq_t                    sq_r  [SQRT_STAGES];
  ctx_t                   sqc_r [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] sq_v_r;

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    sq_t         sv_in, sv_nxt;
    ctx_t        cx_in;
    logic        v_in;
    logic [52:0] tmp, trial;

    if (j == 0) begin : g_first
      assign sv_in = m3_sq_r;
      assign cx_in = m3_ctx_r;
      assign v_in  = m3_v_r;
    end else begin : g_next
      assign sv_in = sq_r[j-1];
      assign cx_in = sqc_r[j-1];
      assign v_in  = sq_v_r[j-1];
    end

    always_comb begin
      tmp        = {sv_in.rem, sv_in.dsh[97:96]};
      trial      = {2'b00, sv_in.root, 2'b01};
      sv_nxt.dsh = {sv_in.dsh[95:0], 2'b00};
      if (tmp >= trial) begin
        sv_nxt.rem  = 51'(tmp - trial);
        sv_nxt.root = {sv_in.root[47:0], 1'b1};
      end else begin
        sv_nxt.rem  = tmp[50:0];
        sv_nxt.root = {sv_in.root[47:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j] <= 1'b0;
      end else if (en) begin
        sq_v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[j]  <= sv_nxt;
        sqc_r[j] <= cx_in;
      end
    end
  end

  // stage F1: root numerator
  logic               f1_v_r;
  ctx_t               f1_ctx_r;
  logic signed [51:0] f1_num_r, s52_nxt, b52_nxt;

  assign s52_nxt = $signed({3'b000, sq_r[SQRT_STAGES-1].root});
  assign b52_nxt = 52'(sqc_r[SQRT_STAGES-1].b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= sq_v_r[SQRT_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_ctx_r <= sqc_r[SQRT_STAGES-1];
      f1_num_r <= (sqc_r[SQRT_STAGES-1].t > 15'sd0) ? (s52_nxt - b52_nxt)
                                                    : (-b52_nxt - s52_nxt);
    end
  end

  // stage F2: scaled bounds
  logic               f2_v_r;
  ctx_t               f2_ctx_r;
  logic signed [51:0] f2_num_r, numneg_nxt;
  logic signed [48:0] f2_tden_r;
  logic        [47:0] f2_cden_r;
  logic        [50:0] f2_nabs_r;
  logic        [32:0] den;

  assign den        = {k1_r, 1'b0};
  assign numneg_nxt = -f1_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (en) begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_ctx_r  <= f1_ctx_r;
      f2_num_r  <= f1_num_r;
      f2_tden_r <= f1_ctx_r.t * $signed({1'b0, den});
      f2_cden_r <= 48'(den) * 48'(TORQUE_CLAMP);
      f2_nabs_r <= f1_num_r[51] ? numneg_nxt[50:0] : f1_num_r[50:0];
    end
  end

  // stage F3: keep / clamp decision
  logic               f3_v_r;
  ctx_t               f3_ctx_r, f3_ctx_nxt;
  qd_t                f3_qd_r;
  logic signed [51:0] tden52, cden52;
  logic               tpos;

  assign tden52 = 52'(f2_tden_r);
  assign cden52 = $signed({4'b0000, f2_cden_r});
  assign tpos   = (f2_ctx_r.t > 15'sd0);

  always_comb begin
    f3_ctx_nxt      = f2_ctx_r;
    f3_ctx_nxt.keep = (tpos && tden52 <= f2_num_r) || (!tpos && tden52 >= f2_num_r);
    f3_ctx_nxt.hi   = (f2_num_r > cden52);
    f3_ctx_nxt.lo   = (f2_num_r < -cden52);
    f3_ctx_nxt.nneg = f2_num_r[51];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_v_r <= 1'b0;
    end else if (en) begin
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_ctx_r    <= f3_ctx_nxt;
      f3_qd_r.rem <= {1'b0, f2_nabs_r};
      f3_qd_r.q   <= '0;
    end
  end

  // root divider, one quotient bit per stage
  qd_t                    qd_r  [QDIV_STAGES];
  ctx_t                   qdc_r [QDIV_STAGES];
  logic [QDIV_STAGES-1:0] qd_v_r;

  for (genvar i = 0; i < QDIV_STAGES; i++) begin : g_qdiv
    localparam int BIT = QDIV_STAGES - 1 - i;
    qd_t         qv_in, qv_nxt;
    ctx_t        cx_in;
    logic        v_in;
    logic [51:0] sub;

    if (i == 0) begin : g_first
      assign qv_in = f3_qd_r;
      assign cx_in = f3_ctx_r;
      assign v_in  = f3_v_r;
    end else begin : g_next
      assign qv_in = qd_r[i-1];
      assign cx_in = qdc_r[i-1];
      assign v_in  = qd_v_r[i-1];
    end

    always_comb begin
      sub    = 52'(den) << BIT;
      qv_nxt = qv_in;
      if (qv_in.rem >= sub) begin
        qv_nxt.rem    = qv_in.rem - sub;
        qv_nxt.q[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qd_v_r[i] <= 1'b0;
      end else if (en) begin
        qd_v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qd_r[i]  <= qv_nxt;
        qdc_r[i] <= cx_in;
      end
    end
  end

  // result select
  ctx_t               lc;
  logic signed [14:0] qs;

  assign lc = qdc_r[QDIV_STAGES-1];
  assign pv = qd_v_r[QDIV_STAGES-1];
  assign qs = $signed(15'(qd_r[QDIV_STAGES-1].q));

  always_comb begin
    pd.expected_power = lc.p;
    pd.status         = ST_NORMAL;
    pd.limited_torque = lc.t;
    if (lc.pass) begin
      pd.status = ST_PASS;
    end else if (k1_r != 32'd0) begin
      if (lc.ndisc) begin
        pd.status = ST_NEG_DISC;
      end
      if (lc.keep) begin
        pd.limited_torque = lc.t;
      end else if (lc.hi) begin
        pd.limited_torque = CLAMP;
      end else if (lc.lo) begin
        pd.limited_torque = -CLAMP;
      end else begin
        pd.limited_torque = lc.nneg ? -qs : qs;
      end
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (out_ch.ready || !out_valid_r) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= pv;
      end
    end else if (pv) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_valid_r) begin
      out_r <= skid_v_r ? skid_r : pd;
    end else if (pv && en) begin
      skid_r <= pd;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.limited_torque = out_r.limited_torque;
  assign out_ch.expected_power = out_r.expected_power;
  assign out_ch.status         = out_r.status;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid holds an item while output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_valid_r && !out_ch.ready && pv))
    else $error("skid filled without a stalled output");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (pv && en) |=> out_valid_r)
    else $error("pipeline item lost at output");

  a_neg_disc_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_NEG_DISC) |-> (k1_r != 32'd0))
    else $error("negative discriminant reported with zero torque gain");

endmodule
